### hw/rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared constants and register indexes for the ray / box slab test
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_AXES        = 3;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_BOX_LOW_X  = 3'd0,
    REG_BOX_LOW_Y  = 3'd1,
    REG_BOX_LOW_Z  = 3'd2,
    REG_BOX_HIGH_X = 3'd3,
    REG_BOX_HIGH_Y = 3'd4,
    REG_BOX_HIGH_Z = 3'd5
  } reg_index_t;

endpackage

### hw/rtl/ray_box_slab_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_core
// ray versus axis-aligned box test by the slab method, signed fixed point
// ----------------------------------------------------------------------------
// usage
//   - box bounds are loaded over the plain write port (cfg_write, cfg_index,
//     cfg_data); the user must load them only while no ray is in flight, the
//     block does not enforce this; indexes beyond the box are ignored
//   - a ray word is taken at each edge where start is high and busy is low;
//     busy is always low, so one ray can be issued every cycle
//   - each ray gives one result word on hit / t_enter / t_exit, marked by a
//     one-cycle done strobe
//   - latency is set by the six parallel restoring dividers, one quotient
//     bit per stage, plus input, prep, slab and combine registers
//   - throughput is one word per cycle with any idle pattern at the input
//   - the receiver cannot stall: results are shown once and must be taken
//   - synchronous reset clears all valid bits and the box registers; rays
//     in flight at reset are dropped
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_core #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [COORD_WIDTH-1:0]          origin_x,
  input  logic signed [COORD_WIDTH-1:0]          origin_y,
  input  logic signed [COORD_WIDTH-1:0]          origin_z,
  input  logic signed [COORD_WIDTH-1:0]          dir_x,
  input  logic signed [COORD_WIDTH-1:0]          dir_y,
  input  logic signed [COORD_WIDTH-1:0]          dir_z,
  input  logic signed [COORD_WIDTH-1:0]          ray_tmin,
  input  logic signed [COORD_WIDTH-1:0]          ray_tmax,
  input  logic                                   cfg_write,
  input  logic [rbsi_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0]                 cfg_data,
  output logic                                   done,
  output logic                                   hit,
  output logic signed [COORD_WIDTH-1:0]          t_enter,
  output logic signed [COORD_WIDTH-1:0]          t_exit
);
  import rbsi_pkg::*;

  localparam int W       = COORD_WIDTH;
  localparam int LATENCY = W + 5;   // start sample to done sample

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  assign busy = 1'b0;

  // box registers
  logic signed [W-1:0] box_low  [NUM_AXES];
  logic signed [W-1:0] box_high [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_low[a]  <= '0;
        box_high[a] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BOX_LOW_X:  box_low[0]  <= cfg_data;
        REG_BOX_LOW_Y:  box_low[1]  <= cfg_data;
        REG_BOX_LOW_Z:  box_low[2]  <= cfg_data;
        REG_BOX_HIGH_X: box_high[0] <= cfg_data;
        REG_BOX_HIGH_Y: box_high[1] <= cfg_data;
        REG_BOX_HIGH_Z: box_high[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: input word register
  logic                in_valid;
  logic signed [W-1:0] in_org [NUM_AXES];
  logic signed [W-1:0] in_dir [NUM_AXES];
  logic signed [W-1:0] in_tmin;
  logic signed [W-1:0] in_tmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_org[0] <= origin_x;
    in_org[1] <= origin_y;
    in_org[2] <= origin_z;
    in_dir[0] <= dir_x;
    in_dir[1] <= dir_y;
    in_dir[2] <= dir_z;
    in_tmin   <= ray_tmin;
    in_tmax   <= ray_tmax;
  end

  // stage 2: offsets, magnitudes, signs and the zero-direction case
  // divider slot k: k < 3 is the low bound of axis k, else high bound of k-3
  logic [W:0]   nmag_next [2*NUM_AXES];
  logic [W-1:0] dmag_next [2*NUM_AXES];
  logic         neg_next  [2*NUM_AXES];
  logic         zero_next   [NUM_AXES];
  logic         inslab_next [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic signed [W:0]   off_lo;
      logic signed [W:0]   off_hi;
      logic                dneg;
      logic [W-1:0]        dm;
      logic signed [W-1:0] mn;
      logic signed [W-1:0] mx;
      off_lo = {box_low[a][W-1], box_low[a]} - {in_org[a][W-1], in_org[a]};
      off_hi = {box_high[a][W-1], box_high[a]} - {in_org[a][W-1], in_org[a]};
      dneg   = in_dir[a][W-1];
      dm     = dneg ? (W'(0) - in_dir[a]) : in_dir[a];
      nmag_next[a]            = off_lo[W] ? -off_lo : off_lo;
      nmag_next[a + NUM_AXES] = off_hi[W] ? -off_hi : off_hi;
      neg_next[a]             = off_lo[W] ^ dneg;
      neg_next[a + NUM_AXES]  = off_hi[W] ^ dneg;
      dmag_next[a]            = dm;
      dmag_next[a + NUM_AXES] = dm;
      mn = (box_low[a] < box_high[a]) ? box_low[a] : box_high[a];
      mx = (box_low[a] < box_high[a]) ? box_high[a] : box_low[a];
      zero_next[a]   = (in_dir[a] == '0);
      inslab_next[a] = (in_org[a] >= mn) && (in_org[a] <= mx);
    end
  end

  logic         prep_valid;
  logic [W:0]   prep_nmag [2*NUM_AXES];
  logic [W-1:0] prep_dmag [2*NUM_AXES];
  logic         prep_neg  [2*NUM_AXES];

  // sideband delay line running beside the prep registers and the dividers (entry stage plus W)
  logic                sb_zero   [W+2][NUM_AXES];
  logic                sb_inslab [W+2][NUM_AXES];
  logic signed [W-1:0] sb_tmin   [W+2];
  logic signed [W-1:0] sb_tmax   [W+2];

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else begin
      prep_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2*NUM_AXES; k++) begin
      prep_nmag[k] <= nmag_next[k];
      prep_dmag[k] <= dmag_next[k];
      prep_neg[k]  <= neg_next[k];
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      sb_zero[0][a]   <= zero_next[a];
      sb_inslab[0][a] <= inslab_next[a];
    end
    sb_tmin[0] <= in_tmin;
    sb_tmax[0] <= in_tmax;
    for (int j = 1; j <= W + 1; j++) begin
      sb_zero[j]   <= sb_zero[j-1];
      sb_inslab[j] <= sb_inslab[j-1];
      sb_tmin[j]   <= sb_tmin[j-1];
      sb_tmax[j]   <= sb_tmax[j-1];
    end
  end

  // six dividers in parallel
  logic                div_valid [2*NUM_AXES];
  logic signed [W-1:0] div_quot  [2*NUM_AXES];

  for (genvar k = 0; k < 2*NUM_AXES; k++) begin : g_div
    rbsi_div_pipe #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (prep_valid),
      .in_nmag   (prep_nmag[k]),
      .in_dmag   (prep_dmag[k]),
      .in_neg    (prep_neg[k]),
      .out_valid (div_valid[k]),
      .out_quot  (div_quot[k])
    );
  end

  // slab stage: per-axis near / far, zero direction gives unbounded or empty
  logic                slab_valid;
  logic signed [W-1:0] slab_near [NUM_AXES];
  logic signed [W-1:0] slab_far  [NUM_AXES];
  logic signed [W-1:0] slab_tmin;
  logic signed [W-1:0] slab_tmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      slab_valid <= 1'b0;
    end else begin
      slab_valid <= div_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (sb_zero[W+1][a]) begin
        slab_near[a] <= sb_inslab[W+1][a] ? SMIN : SMAX;
        slab_far[a]  <= sb_inslab[W+1][a] ? SMAX : SMIN;
      end else if (div_quot[a] < div_quot[a + NUM_AXES]) begin
        slab_near[a] <= div_quot[a];
        slab_far[a]  <= div_quot[a + NUM_AXES];
      end else begin
        slab_near[a] <= div_quot[a + NUM_AXES];
        slab_far[a]  <= div_quot[a];
      end
    end
    slab_tmin <= sb_tmin[W+1];
    slab_tmax <= sb_tmax[W+1];
  end

  // combine stage: largest near, smallest far, clamp to the ray interval
  logic signed [W-1:0] enter_next;
  logic signed [W-1:0] exit_next;

  always_comb begin
    enter_next = slab_tmin;
    exit_next  = slab_tmax;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (slab_near[a] > enter_next) enter_next = slab_near[a];
      if (slab_far[a] < exit_next)   exit_next  = slab_far[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= slab_valid;
    end
  end

  always_ff @(posedge clk) begin
    t_enter <= enter_next;
    t_exit  <= exit_next;
    hit     <= !exit_next[W-1] && (exit_next >= enter_next);
  end

  // checks
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LATENCY) done)
    else $error("ray word did not produce a result after the pipeline depth");

  a_hit_interval: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!t_exit[W-1] && (t_exit >= t_enter)))
    else $error("hit reported on an empty or negative interval");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_valid[0] == div_valid[2*NUM_AXES-1])
    else $error("divider lanes out of step");

endmodule

### hw/rtl/rbsi_div_pipe.sv
// ----------------------------------------------------------------------------
// rbsi_div_pipe
// pipelined restoring divider, one quotient bit per stage, signed saturation
// ----------------------------------------------------------------------------
module rbsi_div_pipe #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [COORD_WIDTH:0]          in_nmag,
  input  logic [COORD_WIDTH-1:0]        in_dmag,
  input  logic                          in_neg,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_quot
);
  import rbsi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DW = 2 * W + F + 1;

  logic [W:0]    valid;
  logic [DW-1:0] rem  [W+1];
  logic [W-1:0]  quot [W+1];
  logic [W-1:0]  dmag [W+1];
  logic          neg  [W+1];
  logic          ovf  [W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[W-1:0], in_valid};
    end
  end

  // entry stage: scaled dividend and overflow precheck (quotient >= 2^W)
  always_ff @(posedge clk) begin
    rem[0]  <= DW'(in_nmag) << F;
    ovf[0]  <= (DW'(in_nmag) << F) >= (DW'(in_dmag) << W);
    quot[0] <= '0;
    dmag[0] <= in_dmag;
    neg[0]  <= in_neg;
  end

  for (genvar s = 1; s <= W; s++) begin : g_stage
    logic [DW-1:0] dsh;
    logic          take;
    assign dsh  = DW'(dmag[s-1]) << (W - s);
    assign take = rem[s-1] >= dsh;
    always_ff @(posedge clk) begin
      rem[s]  <= take ? (rem[s-1] - dsh) : rem[s-1];
      quot[s] <= take ? (quot[s-1] | (W'(1) << (W - s))) : quot[s-1];
      dmag[s] <= dmag[s-1];
      neg[s]  <= neg[s-1];
      ovf[s]  <= ovf[s-1];
    end
  end

  // saturate the magnitude, then apply the sign
  logic [W-1:0] limit;
  logic [W-1:0] qmag;

  always_comb begin
    limit = {1'b0, {(W-1){1'b1}}} + W'(neg[W]);
    qmag  = (ovf[W] || (quot[W] > limit)) ? limit : quot[W];
  end

  assign out_valid = valid[W];
  assign out_quot  = neg[W] ? -qmag : qmag;

endmodule
